FILE: sv/ttp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttp_pkg
// Shared constants and controller/datapath handshake types for the
// loop-point time tag parser.
// ----------------------------------------------------------------------------
package ttp_pkg;

  // character codes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // sizes
  localparam int TIME_FIELDS_DEF = 3;
  localparam int FRAC_DIGITS     = 3;
  localparam int VALUE_W         = 32;
  localparam int CHAR_W          = 8;
  localparam int DIGIT_W         = 4;
  localparam int FRAC_SUM_W      = 10;

  // conversion factors
  localparam logic [VALUE_W-1:0] MUL_FIELD = 32'd60;
  localparam logic [VALUE_W-1:0] MUL_MS    = 32'd1000;

  // commands from controller to datapath
  typedef struct packed {
    logic take;   // accepted beat, parse its character
    logic step;   // fold next field into the time total
    logic ms;     // scale to milliseconds and add fraction
    logic load;   // capture result and clear parse state
  } ttp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic err;         // tag already malformed
    logic samp;        // no colon seen, sample count
    logic last_field;  // fold pointer at the final field
  } ttp_sts_t;

endpackage

FILE: sv/ttp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttp_in_if / ttp_out_if
// Valid/ready channels for tag characters in and parse results out.
// ----------------------------------------------------------------------------
interface ttp_in_if;
  logic                       valid;
  logic                       ready;
  logic [ttp_pkg::CHAR_W-1:0] ch;
  logic                       no_char;
  logic                       last;

  modport source (output valid, ch, no_char, last, input ready);
  modport sink   (input valid, ch, no_char, last, output ready);
endinterface

interface ttp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        valid_res;
  logic                        is_count;
  logic [ttp_pkg::VALUE_W-1:0] time_value;

  modport source (output valid, valid_res, is_count, time_value, input ready);
  modport sink   (input valid, valid_res, is_count, time_value, output ready);
endinterface

FILE: sv/ttp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttp_datapath
// Parse state (field accumulators, fraction digits, mode flags), the
// time-to-milliseconds fold register and the result register.
// ----------------------------------------------------------------------------
module ttp_datapath #(
  parameter int TIME_FIELDS = ttp_pkg::TIME_FIELDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ttp_pkg::CHAR_W-1:0]  ch,
  input  logic                        no_char,
  input  ttp_pkg::ttp_cmd_t           cmd,
  output ttp_pkg::ttp_sts_t           sts,
  output logic                        valid_res,
  output logic                        is_count,
  output logic [ttp_pkg::VALUE_W-1:0] time_value
);

  localparam int FIDX_W = (TIME_FIELDS > 1) ? $clog2(TIME_FIELDS) : 1;
  localparam logic [FIDX_W-1:0] FIDX_TOP = FIDX_W'(TIME_FIELDS - 1);
  localparam logic [1:0] FRAC_MAX = 2'(ttp_pkg::FRAC_DIGITS);

  logic [ttp_pkg::VALUE_W-1:0] field_acc_r [TIME_FIELDS];
  logic [ttp_pkg::VALUE_W-1:0] field_acc_nxt [TIME_FIELDS];
  logic [ttp_pkg::DIGIT_W-1:0] frac_digit_r [ttp_pkg::FRAC_DIGITS];
  logic [ttp_pkg::DIGIT_W-1:0] frac_digit_nxt [ttp_pkg::FRAC_DIGITS];
  logic [FIDX_W-1:0]           field_index_r, field_index_nxt;
  logic [1:0]                  frac_count_r, frac_count_nxt;
  logic                        sample_mode_r, sample_mode_nxt;
  logic                        in_fraction_r, in_fraction_nxt;
  logic                        error_seen_r, error_seen_nxt;
  logic [ttp_pkg::VALUE_W-1:0] t_r, t_nxt;
  logic [FIDX_W-1:0]           idx_r, idx_nxt;
  logic                        valid_res_r, valid_res_nxt;
  logic                        is_count_r, is_count_nxt;
  logic [ttp_pkg::VALUE_W-1:0] time_value_r, time_value_nxt;

  logic [ttp_pkg::DIGIT_W-1:0]    digit;
  logic [ttp_pkg::VALUE_W-1:0]    acc_cur;
  logic [ttp_pkg::FRAC_SUM_W-1:0] frac_sum;

  assign digit   = ttp_pkg::DIGIT_W'(ch - ttp_pkg::CH_ZERO);
  assign acc_cur = field_acc_r[field_index_r];

  // fraction digits weighted as hundreds, tens, units
  assign frac_sum = ttp_pkg::FRAC_SUM_W'(frac_digit_r[0]) * 10'd100
                  + ttp_pkg::FRAC_SUM_W'(frac_digit_r[1]) * 10'd10
                  + ttp_pkg::FRAC_SUM_W'(frac_digit_r[2]);

  assign sts.err        = error_seen_r;
  assign sts.samp       = sample_mode_r;
  assign sts.last_field = (idx_r == field_index_r);

  // next-state logic
  always_comb begin
    field_acc_nxt   = field_acc_r;
    frac_digit_nxt  = frac_digit_r;
    field_index_nxt = field_index_r;
    frac_count_nxt  = frac_count_r;
    sample_mode_nxt = sample_mode_r;
    in_fraction_nxt = in_fraction_r;
    error_seen_nxt  = error_seen_r;
    t_nxt           = t_r;
    idx_nxt         = idx_r;
    valid_res_nxt   = valid_res_r;
    is_count_nxt    = is_count_r;
    time_value_nxt  = time_value_r;

    // character parse
    if (cmd.take && !no_char && !error_seen_r) begin
      if (ch inside {[ttp_pkg::CH_ZERO:ttp_pkg::CH_NINE]}) begin
        if (in_fraction_r) begin
          if (frac_count_r < FRAC_MAX) begin
            frac_digit_nxt[frac_count_r] = digit;
            frac_count_nxt = frac_count_r + 2'd1;
          end
        end else begin
          field_acc_nxt[field_index_r] = (acc_cur << 3) + (acc_cur << 1)
                                       + ttp_pkg::VALUE_W'(digit);
        end
      end else if (ch == ttp_pkg::CH_COLON) begin
        if (in_fraction_r) begin
          error_seen_nxt = 1'b1;
        end else begin
          sample_mode_nxt = 1'b0;
          if (field_index_r == FIDX_TOP) begin
            error_seen_nxt = 1'b1;
          end else begin
            field_index_nxt = field_index_r + 1'b1;
          end
        end
      end else if (ch == ttp_pkg::CH_DOT) begin
        if (sample_mode_r || in_fraction_r) begin
          error_seen_nxt = 1'b1;
        end else begin
          in_fraction_nxt = 1'b1;
        end
      end else begin
        error_seen_nxt = 1'b1;
      end
    end

    // fold one field: t = t*60 + field
    if (cmd.step) begin
      t_nxt = t_r * ttp_pkg::MUL_FIELD + field_acc_r[idx_r];
      if (!sts.last_field) begin
        idx_nxt = idx_r + 1'b1;
      end
    end

    // scale to milliseconds
    if (cmd.ms) begin
      t_nxt = t_r * ttp_pkg::MUL_MS + ttp_pkg::VALUE_W'(frac_sum);
    end

    // capture result, clear for next tag
    if (cmd.load) begin
      if (error_seen_r) begin
        valid_res_nxt  = 1'b0;
        is_count_nxt   = 1'b0;
        time_value_nxt = '0;
      end else if (sample_mode_r) begin
        valid_res_nxt  = 1'b1;
        is_count_nxt   = 1'b1;
        time_value_nxt = field_acc_r[0];
      end else begin
        valid_res_nxt  = 1'b1;
        is_count_nxt   = 1'b0;
        time_value_nxt = t_r;
      end
      for (int i = 0; i < TIME_FIELDS; i++) field_acc_nxt[i] = '0;
      for (int i = 0; i < ttp_pkg::FRAC_DIGITS; i++) frac_digit_nxt[i] = '0;
      field_index_nxt = '0;
      frac_count_nxt  = '0;
      sample_mode_nxt = 1'b1;
      in_fraction_nxt = 1'b0;
      error_seen_nxt  = 1'b0;
      t_nxt           = '0;
      idx_nxt         = '0;
    end
  end

  // parse and fold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TIME_FIELDS; i++) field_acc_r[i] <= '0;
      for (int i = 0; i < ttp_pkg::FRAC_DIGITS; i++) frac_digit_r[i] <= '0;
      field_index_r <= '0;
      frac_count_r  <= '0;
      sample_mode_r <= 1'b1;
      in_fraction_r <= 1'b0;
      error_seen_r  <= 1'b0;
      t_r           <= '0;
      idx_r         <= '0;
    end else begin
      field_acc_r   <= field_acc_nxt;
      frac_digit_r  <= frac_digit_nxt;
      field_index_r <= field_index_nxt;
      frac_count_r  <= frac_count_nxt;
      sample_mode_r <= sample_mode_nxt;
      in_fraction_r <= in_fraction_nxt;
      error_seen_r  <= error_seen_nxt;
      t_r           <= t_nxt;
      idx_r         <= idx_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    valid_res_r  <= valid_res_nxt;
    is_count_r   <= is_count_nxt;
    time_value_r <= time_value_nxt;
  end

  assign valid_res  = valid_res_r;
  assign is_count   = is_count_r;
  assign time_value = time_value_r;

endmodule

FILE: sv/ttp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttp_ctrl
// Sequencer: takes character beats, runs the field fold and millisecond
// scaling after the last beat, and owns the result valid flag.
// ----------------------------------------------------------------------------
module ttp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ttp_pkg::ttp_sts_t sts,
  output ttp_pkg::ttp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIELD,
    S_MS,
    S_LOAD
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // commands
  assign cmd.take = in_valid && in_ready;
  assign cmd.step = (state_r == S_FIELD) && !sts.err && !sts.samp;
  assign cmd.ms   = (state_r == S_MS);
  assign cmd.load = (state_r == S_LOAD) && (!out_valid_r || out_ready);

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd.take && in_last) state_r <= S_FIELD;
        end
        S_FIELD: begin
          if (sts.err || sts.samp) state_r <= S_LOAD;
          else if (sts.last_field) state_r <= S_MS;
        end
        S_MS: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          if (cmd.load) state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (cmd.load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

endmodule

FILE: sv/time_tag_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_tag_parser_top
// Character-serial parser for loop-point tags (sample count or HH:MM:SS.fff).
// ----------------------------------------------------------------------------
// Each beat carries one tag character; a beat with last set closes the tag and
// produces one result (validity, samples/time flag, value in samples or
// milliseconds modulo 2^32). A non-last beat leaves the sequencer idle. After
// a last beat an error or a sample count goes from S_FIELD to S_LOAD; a time
// value stays in S_FIELD for the n time fields present (at most TIME_FIELDS),
// since the fold t = t*60 + field runs one field a cycle through a single
// constant multiplier, then passes through S_MS for the millisecond scaling
// and on to S_LOAD. The result sits in an output register, so the next tag's
// characters are taken while it waits; after a further last beat the input
// stalls until that register has been read and the new result is loaded.
// ----------------------------------------------------------------------------
module time_tag_parser_top #(
  parameter int TIME_FIELDS = ttp_pkg::TIME_FIELDS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ttp_in_if.sink    in_if,
  ttp_out_if.source out_if
);

  ttp_pkg::ttp_cmd_t cmd;
  ttp_pkg::ttp_sts_t sts;

  // sequencer
  ttp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_last   (in_if.last),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // parse state and arithmetic
  ttp_datapath #(
    .TIME_FIELDS (TIME_FIELDS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ch         (in_if.ch),
    .no_char    (in_if.no_char),
    .cmd        (cmd),
    .sts        (sts),
    .valid_res  (out_if.valid_res),
    .is_count   (out_if.is_count),
    .time_value (out_if.time_value)
  );

endmodule

FILE: sv/ttp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttp_checker
// Port-level checks on the time tag parser, bound to the top level.
// ----------------------------------------------------------------------------
module ttp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        valid_res,
  input logic                        is_count,
  input logic [ttp_pkg::VALUE_W-1:0] time_value
);

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  // result stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(time_value)
      && $stable(valid_res) && $stable(is_count))
    else $error("result changed while stalled");

  // malformed tag reports zero flags and value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !valid_res |-> !is_count && (time_value == '0))
    else $error("malformed result carries nonzero fields");

  // closing beat starts the fold, no beat taken next cycle
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_last |=> !in_ready)
    else $error("beat accepted during result computation");

  // a non-closing beat never makes a result appear
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && !in_last && !out_valid |=> !out_valid)
    else $error("result without closing beat");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind time_tag_parser_top ttp_checker u_ttp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .in_last    (in_if.last),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .valid_res  (out_if.valid_res),
  .is_count   (out_if.is_count),
  .time_value (out_if.time_value)
);
